@@ src/lcdbg_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdbg_pkg
// shared constants for the lcd bar graph nibble writer
// ----------------------------------------------------------------------------
package lcdbg_pkg;

	localparam logic [7:0] CMD_ROW0    = 8'h80;
	localparam logic [7:0] CMD_ROW1    = 8'hC0;
	localparam logic [6:0] PERCENT_MAX = 7'd99;
	localparam logic [7:0] SPACE_CODE  = 8'h20;
	localparam logic [7:0] DIGIT_ZERO  = 8'h30;

	// register-select codes
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// configuration register indexes
	localparam logic REG_FILL_CODE = 1'b0;

	// command nibbles that can appear with register select low
	localparam logic [3:0] CMD_NIB_ROW0 = CMD_ROW0[7:4];
	localparam logic [3:0] CMD_NIB_ROW1 = CMD_ROW1[7:4];
	localparam logic [3:0] CMD_NIB_LOW  = CMD_ROW0[3:0];

endpackage

@@ src/lcd_bar_graph_nibble_writer.sv @@
// ----------------------------------------------------------------------------
// lcd_bar_graph_nibble_writer
// renders a row select and percent value as a 4-bit lcd bar graph line
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one word per line: tuser is the row, tdata the percent
//   (values above 99 are shown as 99). m_* gives one word per enable
//   strobe: tdata holds the nibble for d7..d4, tuser the register select,
//   tlast marks the final nibble of the line.
//   a line is a cursor command, BAR_CELLS bar cells and two decimal digits,
//   each byte sent high nibble first: 2*(BAR_CELLS+3) words, 34 by default.
//   the input word is registered, then its first nibble goes to the output register.
//   the nibble counter emits one word per cycle unless m_tready stalls the
//   output register; the next input word is taken in the cycle the
//   final nibble of the current line moves to the output register.
//   the fill character comes from register fill_code at apb address 0.
//   reset empties the line holding register and the output register and
//   sets fill_code to 0. a stall on m_tready holds the output word and the
//   nibble counter; s_tready drops until the line is nearly sent.
// ----------------------------------------------------------------------------
module lcd_bar_graph_nibble_writer
	import lcdbg_pkg::*;
#(
	parameter int BAR_CELLS = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	// apb configuration port
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] percent
	input  logic       s_tuser,   // [0] row
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] nibble, [7:4] zero
	output logic       m_tuser,   // [0] reg_select
	output logic       m_tlast
);

	localparam int NIB_COUNT = 2 * (BAR_CELLS + 3);
	localparam int POS_W     = $clog2(NIB_COUNT);
	localparam int BYTE_W    = POS_W - 1;
	localparam int PROD_W    = $clog2(99 * BAR_CELLS + 1);
	localparam int CMP_W     = $clog2(100 * BAR_CELLS + 1);

	logic [7:0] fill_code_q;

	logic              busy_q;
	logic              row_q;
	logic [PROD_W-1:0] prod_q;
	logic [3:0]        tens_q;
	logic [3:0]        ones_q;
	logic [POS_W-1:0]  pos_q;

	logic              out_valid_q;
	logic [3:0]        out_nib_q;
	logic              out_rs_q;
	logic              out_last_q;

	logic        cfg_wr;
	logic        accept;
	logic        advance;
	logic        pos_end;
	logic [6:0]  pct_c;
	logic [14:0] tens_prod_c;
	logic [3:0]  tens_c;
	logic [BYTE_W-1:0] byte_idx;
	logic [BYTE_W-1:0] cell_idx;
	logic [CMP_W-1:0]  cell_scaled;
	logic [7:0]  byte_c;
	logic [3:0]  nib_c;

	// apb register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_FILL_CODE) ? {24'd0, fill_code_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_code_q <= 8'd0;
		end else if (cfg_wr && paddr[2] == REG_FILL_CODE) begin
			fill_code_q <= pwdata[7:0];
		end
	end

	// input side
	assign pct_c       = (s_tdata > {1'b0, PERCENT_MAX}) ? PERCENT_MAX : s_tdata[6:0];
	assign tens_prod_c = {8'd0, pct_c} * 15'd205;
	assign tens_c      = tens_prod_c[14:11];

	assign pos_end  = (pos_q == POS_W'(NIB_COUNT - 1));
	assign advance  = busy_q && (!out_valid_q || m_tready);
	assign s_tready = !busy_q || (advance && pos_end);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (advance) begin
				pos_q <= pos_end ? '0 : pos_q + POS_W'(1);
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (advance && pos_end) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= s_tuser;
			prod_q <= PROD_W'(pct_c * BAR_CELLS);
			tens_q <= tens_c;
			ones_q <= 4'(pct_c - 7'(tens_c) * 7'd10);
		end
	end

	// byte and nibble select
	assign byte_idx    = pos_q[POS_W-1:1];
	assign cell_idx    = byte_idx - BYTE_W'(1);
	assign cell_scaled = CMP_W'(32'(cell_idx) * 100);

	always_comb begin
		if (byte_idx == '0) begin
			byte_c = row_q ? CMD_ROW1 : CMD_ROW0;
		end else if (byte_idx <= BYTE_W'(BAR_CELLS)) begin
			byte_c = (cell_scaled < CMP_W'(prod_q)) ? fill_code_q : SPACE_CODE;
		end else if (byte_idx == BYTE_W'(BAR_CELLS + 1)) begin
			byte_c = DIGIT_ZERO | {4'd0, tens_q};
		end else begin
			byte_c = DIGIT_ZERO | {4'd0, ones_q};
		end
	end

	assign nib_c = pos_q[0] ? byte_c[3:0] : byte_c[7:4];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_nib_q  <= nib_c;
			out_rs_q   <= (byte_idx == '0) ? RS_CMD : RS_DATA;
			out_last_q <= pos_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_nib_q};
	assign m_tuser  = out_rs_q;
	assign m_tlast  = out_last_q;

endmodule

@@ src/lcdbg_checker.sv @@
// ----------------------------------------------------------------------------
// lcdbg_checker
// port-level checks on the nibble output stream
// ----------------------------------------------------------------------------
module lcdbg_checker
	import lcdbg_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed under stall");

	// line ends on a data nibble
	a_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == RS_DATA)
		else $error("last word is not character data");

	// final nibble is the low half of a decimal digit
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[3:0] <= 4'd9)
		else $error("last word is not a decimal digit");

	// command nibbles come only from the cursor commands
	a_cmd_nib: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RS_CMD |-> m_tdata[3:0] == CMD_NIB_ROW0
			|| m_tdata[3:0] == CMD_NIB_ROW1 || m_tdata[3:0] == CMD_NIB_LOW)
		else $error("unexpected command nibble");

endmodule

bind lcd_bar_graph_nibble_writer lcdbg_checker u_lcdbg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ dv/lcd_bar_graph_nibble_writer_tb.sv @@
// ----------------------------------------------------------------------------
// lcd_bar_graph_nibble_writer_tb
// self-checking bench for the 4-bit lcd bar graph line writer
// ----------------------------------------------------------------------------
// row/percent words go in on the slave stream, back to back or in random bursts. A line
// predictor expands each taken word into its cursor command, bar cells and
// two digits, nibble by nibble, and every nibble word leaving the master
// stream is checked against it in order. The fill character is changed over
// apb between phases, with an out-of-range write and read-back checks.
// ----------------------------------------------------------------------------
module lcd_bar_graph_nibble_writer_tb;
	import lcdbg_pkg::*;

	localparam int BAR_CELLS    = 14;
	localparam int REG_SPARE    = 1;     // first index past the register list
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 2 * (BAR_CELLS + 3) + 8;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 48;

	typedef struct packed {
		logic       row;
		logic [7:0] percent;
	} line_req_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       last;
	} strobe_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] percent
	logic        s_tuser;   // [0] row
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [3:0] nibble, [7:4] zero
	logic        m_tuser;   // [0] reg_select
	logic        m_tlast;

	line_req_t   lines_to_send[$];
	strobe_t     strobes_due[$];
	logic [7:0]  fill_model;
	int          fail_count;
	int          lines_taken;
	int          words_checked;
	int          fill_writes;
	int          quiet_cycles;
	logic        s_taken;
	int          burst_left;
	int          gap_left;
	bit          bursty;
	int          stall_mode;
	logic [15:0] ready_pattern;
	int          pattern_age;

	lcd_bar_graph_nibble_writer #(
		.BAR_CELLS(BAR_CELLS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// byte as two nibble words, high nibble first
	function automatic void push_byte(logic [7:0] value, logic rs, logic is_last);
		strobes_due.push_back('{nibble: value[7:4], reg_select: rs, last: 1'b0});
		strobes_due.push_back('{nibble: value[3:0], reg_select: rs, last: is_last});
	endfunction

	function automatic void render_line(logic row, logic [7:0] percent);
		logic [6:0] shown;
		int         cells_on;
		shown    = (percent > 8'(PERCENT_MAX)) ? PERCENT_MAX : percent[6:0];
		cells_on = (int'(shown) * BAR_CELLS + 99) / 100;
		if (cells_on > BAR_CELLS)
			cells_on = BAR_CELLS;
		push_byte(row ? CMD_ROW1 : CMD_ROW0, RS_CMD, 1'b0);
		for (int i = 0; i < BAR_CELLS; i++)
			push_byte(i < cells_on ? fill_model : SPACE_CODE, RS_DATA, 1'b0);
		push_byte(DIGIT_ZERO + 8'(shown / 10), RS_DATA, 1'b0);
		push_byte(DIGIT_ZERO + 8'(shown % 10), RS_DATA, 1'b1);
	endfunction

	function automatic logic [7:0] pick_percent();
		case ($urandom_range(0, 9))
			6: return 8'($urandom_range(100, 255));
			7: return 8'($urandom_range(0, 255));
			8: return ($urandom_range(0, 1) != 0) ? 8'd99 : 8'd0;
			9: return 8'(($urandom_range(0, 13) * 100 + 13) / 14 + $urandom_range(0, 1));
			default: return 8'($urandom_range(0, 99));
		endcase
	endfunction

	// sender: bursts of words, with random gaps when bursty is set
	always @(negedge clk) begin
		line_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_taken) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (lines_to_send.size() > 0) begin
				req = lines_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= req.percent;
				s_tuser  <= req.row;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 8);
					if (bursty)
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45)
							: $urandom_range(0, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: rotating stall pattern, reloaded now and then
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready      <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			pattern_age++;
			if (pattern_age >= 16 + $urandom_range(0, 40)) begin
				pattern_age = 0;
				case (stall_mode)
					0: ready_pattern = 16'hFFFF;
					1: ready_pattern = 16'($urandom) | 16'($urandom);
					default: ready_pattern = ($urandom_range(0, 3) == 0) ? 16'h0001
						: 16'($urandom);
				endcase
			end
		end
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		strobe_t want;
		s_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (strobes_due.size() == 0) begin
					$error("unexpected word: tdata=%h tuser=%b tlast=%b",
						m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					want = strobes_due.pop_front();
					words_checked++;
					if (m_tdata !== {4'b0, want.nibble}) begin
						$error("nibble: expected %h, got %h", want.nibble, m_tdata);
						fail_count++;
					end
					if (m_tuser !== want.reg_select) begin
						$error("reg_select: expected %b, got %b", want.reg_select, m_tuser);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %b, got %b", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				render_line(s_tuser, s_tdata);
				lines_taken++;
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || psel
					|| (lines_to_send.size() == 0 && !s_tvalid && strobes_due.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic apb_write(int idx, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * idx);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == int'(REG_FILL_CODE))
			fill_model = data[7:0];
		fill_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_fill_readback();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 3'(4 * REG_FILL_CODE);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== fill_model) begin
			$error("fill_code: expected %h, got %h", fill_model, prdata[7:0]);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (lines_to_send.size() > 0 || s_tvalid || strobes_due.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0] directed[$];
		logic [7:0] new_fill;
		directed = '{8'd0, 8'd1, 8'd7, 8'd8, 8'd9, 8'd50, 8'd92, 8'd93, 8'd98, 8'd99,
			8'd100, 8'd127, 8'd128, 8'd200, 8'd254, 8'd255, 8'd85, 8'd42};
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		m_tready      = 1'b0;
		s_taken       = 1'b0;
		fill_model    = 8'h00;
		fail_count    = 0;
		lines_taken   = 0;
		words_checked = 0;
		fill_writes   = 0;
		quiet_cycles  = 0;
		burst_left    = 1000;
		gap_left      = 0;
		bursty        = 1'b0;
		stall_mode    = 0;
		ready_pattern = 16'hFFFF;
		pattern_age   = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset fill character, back to back words, no stalls
		check_fill_readback();
		foreach (directed[i])
			lines_to_send.push_back('{row: 1'(i), percent: directed[i]});
		wait_drained();

		for (int ph = 1; ph <= PHASES; ph++) begin
			case (ph)
				1: new_fill = 8'hFF;
				3: new_fill = 8'h00;
				default: new_fill = 8'($urandom);
			endcase
			apb_write(int'(REG_FILL_CODE), {24'($urandom), new_fill});
			if (ph == 2)
				apb_write(REG_SPARE, $urandom);
			check_fill_readback();
			stall_mode = ph % 3;
			bursty     = (ph != 3);
			burst_left = 1;
			if (ph == 1)
				foreach (directed[i])
					lines_to_send.push_back('{row: ~1'(i), percent: directed[i]});
			for (int n = 0; n < PHASE_ITEMS; n++)
				lines_to_send.push_back('{row: 1'($urandom), percent: pick_percent()});
			wait_drained();
		end

		$display("covered %0d lines, %0d nibble words, %0d register writes",
			lines_taken, words_checked, fill_writes);
		$display("fill codes included 00 and ff, stall patterns and sender gaps varied");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
